FILE: src/gre_pkg.sv
package gre_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TRUNC   = 3'd1;
    localparam logic [2:0] ST_NESTED  = 3'd2;
    localparam logic [2:0] ST_BAD_V0  = 3'd3;
    localparam logic [2:0] ST_BAD_V1  = 3'd4;
    localparam logic [2:0] ST_BAD_VER = 3'd5;

    localparam logic [2:0] VER_RFC1701 = 3'd0;
    localparam logic [2:0] VER_PPTP    = 3'd1;

    localparam logic [15:0] PPP_PROTOCOL = 16'h880B;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       already_encapsulated;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] header_length;
        logic [15:0] next_protocol;
    } t_out_item;

endpackage

FILE: src/gre_fifo.sv
module gre_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/gre_front.sv
module gre_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gre_pkg::t_in_item i_item,
    input  logic              i_queue_full,
    output logic              o_full,
    output logic              o_enqueue
);

    logic r_in_packet;
    logic accept;

    assign o_full = i_queue_full;
    assign accept = i_push && !i_queue_full;

    // Bytes outside a packet are dropped here so the parser only sees framed bytes.
    assign o_enqueue = accept && (i_item.first_byte || r_in_packet);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
        end else if (accept) begin
            if (i_item.last_byte) begin
                r_in_packet <= 1'b0;
            end else if (i_item.first_byte) begin
                r_in_packet <= 1'b1;
            end
        end
    end

endmodule

FILE: src/gre_back.sv
module gre_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gre_pkg::t_in_item  i_item,
    input  logic               i_valid,
    input  logic               i_res_full,
    output logic               o_take,
    output logic               o_res_valid,
    output gre_pkg::t_out_item o_res
);

    localparam int LW = LENGTH_BITS;
    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_WALK,
        PH_PAYLOAD
    } t_phase;

    t_phase         r_phase, n_phase, e_phase;
    logic [LW-1:0]  r_count, n_count, e_count;
    logic [7:0]     r_hb, n_hb, e_hb;
    logic [7:0]     r_lb, n_lb, e_lb;
    logic [15:0]    r_proto, n_proto, e_proto;
    logic [LW-1:0]  r_hend, n_hend, e_hend;
    logic [15:0]    r_fam, n_fam, e_fam;
    logic [7:0]     r_rlen, n_rlen;
    logic [2:0]     r_verdict, n_verdict, e_verdict;
    logic           r_nested, n_nested;

    logic [7:0]     b;
    logic           first;
    logic [LW-1:0]  route_base;
    logic [LW+1:0]  route_next;
    logic [15:0]    proto_full;
    logic [2:0]     version;
    logic           v0_bad;
    logic           v1_bad;
    logic [4:0]     v0_len;
    logic [4:0]     v1_len;
    logic [2:0]     status;
    logic [31:0]    hend_wide;
    logic           walk_open;

    assign o_take      = i_valid && !i_res_full;
    assign o_res_valid = o_take && i_item.last_byte;

    assign b     = i_item.data_byte;
    assign first = i_item.first_byte;

    // A first mark restarts the packet: work from the reset values.
    assign e_phase   = first ? PH_HEAD : r_phase;
    assign e_count   = first ? '0 : r_count;
    assign e_hb      = first ? '0 : r_hb;
    assign e_lb      = first ? '0 : r_lb;
    assign e_proto   = first ? '0 : r_proto;
    assign e_hend    = first ? '0 : r_hend;
    assign e_fam     = first ? '0 : r_fam;
    assign e_verdict = first ? '0 : r_verdict;

    assign proto_full = {e_proto[15:8], b};
    assign version    = e_lb[2:0];
    assign v0_bad     = (e_hb[2:0] != 3'd0) || (e_lb[7:3] != 5'd0);
    assign v1_bad     = ((e_hb & 8'hC8) != 8'h00) || (e_hb[2:0] != 3'd0)
                        || ((e_lb & 8'h78) != 8'h00)
                        || (proto_full != gre_pkg::PPP_PROTOCOL) || !e_hb[5];
    assign v0_len     = 5'd4 + ((e_hb[7:6] != 2'b00) ? 5'd4 : 5'd0)
                        + (e_hb[5] ? 5'd4 : 5'd0) + (e_hb[4] ? 5'd4 : 5'd0)
                        + (e_hb[6] ? 5'd4 : 5'd0);
    assign v1_len     = 5'd8 + (e_hb[4] ? 5'd4 : 5'd0) + (e_lb[7] ? 5'd4 : 5'd0);

    // The current route entry header occupies the four bytes before header_end.
    assign route_base = e_hend - LW'(4);
    assign route_next = (LW+2)'(e_hend) + (LW+2)'(b) + (LW+2)'(4);

    always_comb begin
        n_phase   = e_phase;
        n_count   = (e_count == LEN_MAX) ? e_count : e_count + LW'(1);
        n_hb      = e_hb;
        n_lb      = e_lb;
        n_proto   = e_proto;
        n_hend    = e_hend;
        n_fam     = e_fam;
        n_rlen    = first ? 8'd0 : r_rlen;
        n_verdict = e_verdict;
        n_nested  = first ? i_item.already_encapsulated : r_nested;

        if (e_count != LEN_MAX) begin
            if (e_phase == PH_HEAD) begin
                if (e_count == LW'(0)) begin
                    n_hb = b;
                end else if (e_count == LW'(1)) begin
                    n_lb = b;
                end else if (e_count == LW'(2)) begin
                    n_proto = {b, 8'h00};
                end else if (e_count == LW'(3)) begin
                    n_proto = proto_full;
                    n_phase = PH_PAYLOAD;
                    if (version == gre_pkg::VER_RFC1701) begin
                        if (v0_bad) begin
                            n_verdict = gre_pkg::ST_BAD_V0;
                        end else begin
                            n_hend = LW'(v0_len);
                            if (e_hb[6]) begin
                                n_phase = PH_WALK;
                            end
                        end
                    end else if (version == gre_pkg::VER_PPTP) begin
                        if (v1_bad) begin
                            n_verdict = gre_pkg::ST_BAD_V1;
                        end else begin
                            n_hend = LW'(v1_len);
                        end
                    end else begin
                        n_verdict = gre_pkg::ST_BAD_VER;
                    end
                end
            end else if (e_phase == PH_WALK) begin
                if (e_count == route_base) begin
                    n_fam = {b, 8'h00};
                end else if (e_count == route_base + LW'(1)) begin
                    n_fam = {e_fam[15:8], b};
                end else if (e_count == route_base + LW'(3)) begin
                    n_rlen = b;
                    if (e_fam == 16'd0 && b == 8'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else if (route_next > (LW+2)'(LEN_MAX)) begin
                        n_hend    = LEN_MAX;
                        n_verdict = gre_pkg::ST_TRUNC;
                        n_phase   = PH_PAYLOAD;
                    end else begin
                        n_hend = route_next[LW-1:0];
                    end
                end
            end
        end

        // The status looks at the phase after this byte, before the packet closes.
        walk_open = (n_phase == PH_WALK);

        if (i_item.last_byte) begin
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        priority if (n_count < LW'(4)) begin
            status = gre_pkg::ST_TRUNC;
        end else if (n_nested) begin
            status = gre_pkg::ST_NESTED;
        end else if (n_verdict != gre_pkg::ST_OK) begin
            status = n_verdict;
        end else if (walk_open || n_hend > n_count) begin
            status = gre_pkg::ST_TRUNC;
        end else begin
            status = gre_pkg::ST_OK;
        end
    end

    assign hend_wide = 32'(n_hend);

    always_comb begin
        o_res.status        = status;
        o_res.header_length = (status == gre_pkg::ST_OK) ? hend_wide[15:0] : 16'd0;
        o_res.next_protocol = (status == gre_pkg::ST_OK) ? n_proto : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_hb      <= '0;
            r_lb      <= '0;
            r_proto   <= '0;
            r_hend    <= '0;
            r_fam     <= '0;
            r_rlen    <= '0;
            r_verdict <= '0;
            r_nested  <= 1'b0;
        end else if (o_take) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_hb      <= n_hb;
            r_lb      <= n_lb;
            r_proto   <= n_proto;
            r_hend    <= n_hend;
            r_fam     <= n_fam;
            r_rlen    <= n_rlen;
            r_verdict <= n_verdict;
            r_nested  <= n_nested;
        end
    end

endmodule

FILE: src/gre_header_parser.sv
// GRE header parser. Push one packet byte per item with its first and last
// marks; the already_encapsulated bit is taken with the first byte. For every
// packet one result appears on the result side after its last byte: status,
// header length and next protocol (both zero unless the status is ok).
// Bytes that arrive outside a packet are dropped without a result, and a
// first mark inside an open packet abandons it silently. One byte is taken
// every cycle while the result queue has room; the limit is the per-byte
// update of the parser state. A result becomes visible once its last byte
// has passed the byte queue and the parser has written the result into the
// result queue. Header and byte counts saturate at 2^LENGTH_BITS - 1.
module gre_header_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  gre_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output gre_pkg::t_out_item o_out_item
);

    localparam int IN_W  = $bits(gre_pkg::t_in_item);
    localparam int OUT_W = $bits(gre_pkg::t_out_item);

    logic               q_full;
    logic               q_empty;
    logic               q_wr;
    gre_pkg::t_in_item  q_head;
    logic               take;
    logic               res_valid;
    logic               res_full;
    gre_pkg::t_out_item res_item;

    gre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in_item),
        .i_queue_full (q_full),
        .o_full       (full),
        .o_enqueue    (q_wr)
    );

    gre_fifo #(
        .DEPTH (2),
        .WIDTH (IN_W)
    ) u_byte_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (i_in_item),
        .i_rd      (take),
        .o_rd_data (q_head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    gre_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_head),
        .i_valid     (!q_empty),
        .i_res_full  (res_full),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res_item)
    );

    gre_fifo #(
        .DEPTH (2),
        .WIDTH (OUT_W)
    ) u_result_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res_item),
        .i_rd      (pop),
        .o_rd_data (o_out_item),
        .o_full    (res_full),
        .o_empty   (empty)
    );

`ifndef SYNTHESIS
    a_result_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !res_full)
        else $error("result written into a full result queue");

    a_byte_queue_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> (push && !full))
        else $error("byte queued without an accepted input item");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.status <= gre_pkg::ST_BAD_VER))
        else $error("result status out of range");

    a_error_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.status != gre_pkg::ST_OK)
        |-> (o_out_item.header_length == 16'd0 && o_out_item.next_protocol == 16'd0))
        else $error("failed result carries nonzero length or protocol");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LEN_BITS = 16;
    localparam int unsigned LEN_LIMIT = (1 << LEN_BITS) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BYTES = 900;
    localparam gre_pkg::t_out_item NO_RESULT = '0;

    typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_WALK, PH_PAYLOAD} t_parse_phase;

    typedef struct {
        gre_pkg::t_in_item  item;
        bit                 typed;
        gre_pkg::t_out_item want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    gre_pkg::t_in_item  i_in_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    gre_pkg::t_out_item o_out_item;

    gre_header_parser #(.LENGTH_BITS(LEN_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Parser state as the block should hold it.
    t_parse_phase pk_phase = PH_IDLE;
    int unsigned  pk_count = 0;
    logic [7:0]   pk_flags_hi = '0;
    logic [7:0]   pk_flags_lo = '0;
    logic [15:0]  pk_proto = '0;
    int unsigned  pk_hdr_end = 0;
    logic [15:0]  pk_route_fam = '0;
    logic [7:0]   pk_route_len = '0;
    logic [2:0]   pk_error = gre_pkg::ST_OK;
    logic         pk_nested = 1'b0;

    gre_pkg::t_out_item gre_results[$];
    logic [7:0]         pkt_bytes[$];
    gre_pkg::t_out_item want_item;
    int                 fail_count = 0;
    int                 results_checked = 0;
    int                 bytes_accepted = 0;
    int                 packets_sent = 0;
    int                 burst_left = 0;
    int                 stall_cycles = 0;
    logic [15:0]        rx_tick = '0;

    t_stim_row directed_rows[$] = '{
        // stray byte while idle: ignored
        '{'{8'hFF, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b1, 1'b1, 1'b0}, 1'b1, '{gre_pkg::ST_TRUNC, 16'd0, 16'h0000}},
        // packet abandoned after two bytes by a new first mark
        '{'{8'h40, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h08, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b1, '{gre_pkg::ST_OK, 16'd4, 16'h0800}},
        '{'{8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h08, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b1, '{gre_pkg::ST_NESTED, 16'd0, 16'h0000}},
        '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 1'b0, 1'b1, 1'b0}, 1'b1, '{gre_pkg::ST_BAD_VER, 16'd0, 16'h0000}},
        '{'{8'h07, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b0, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 1'b0, 1'b1, 1'b1}, 1'b1, '{gre_pkg::ST_BAD_V0, 16'd0, 16'h0000}},
        // PPTP header with the key bit clear
        '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h01, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h88, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{8'h0B, 1'b0, 1'b1, 1'b0}, 1'b1, '{gre_pkg::ST_BAD_V1, 16'd0, 16'h0000}}
    };

    // Advances the parser by one byte; returns 1 when the byte closes a packet.
    function automatic bit gre_predict(input gre_pkg::t_in_item it,
                                       output gre_pkg::t_out_item res);
        int unsigned pos;
        int unsigned hlen;
        int unsigned base;
        logic [2:0]  ver;
        logic [2:0]  st;
        res = '0;
        if (it.first_byte) begin
            pk_count = 0;
            pk_flags_hi = '0;
            pk_flags_lo = '0;
            pk_proto = '0;
            pk_hdr_end = 0;
            pk_route_fam = '0;
            pk_route_len = '0;
            pk_error = gre_pkg::ST_OK;
            pk_phase = PH_HEAD;
            pk_nested = it.already_encapsulated;
        end else if (pk_phase == PH_IDLE) begin
            return 1'b0;
        end

        pos = pk_count;
        if (pk_count < LEN_LIMIT) pk_count++;

        if (pos < LEN_LIMIT && pk_phase == PH_HEAD) begin
            case (pos)
                0: pk_flags_hi = it.data_byte;
                1: pk_flags_lo = it.data_byte;
                2: pk_proto = {it.data_byte, 8'h00};
                3: begin
                    pk_proto = pk_proto | {8'h00, it.data_byte};
                    ver = pk_flags_lo[2:0];
                    hlen = 4;
                    pk_phase = PH_PAYLOAD;
                    if (ver == gre_pkg::VER_RFC1701) begin
                        if (pk_flags_hi[2:0] != 3'b000 || pk_flags_lo[7:3] != 5'b00000) begin
                            pk_error = gre_pkg::ST_BAD_V0;
                        end else begin
                            // Checksum and routing share one checksum/offset word.
                            if (pk_flags_hi[7] || pk_flags_hi[6]) hlen += 4;
                            if (pk_flags_hi[5]) hlen += 4;
                            if (pk_flags_hi[4]) hlen += 4;
                            if (pk_flags_hi[6]) begin
                                hlen += 4;
                                pk_phase = PH_WALK;
                            end
                            pk_hdr_end = hlen;
                        end
                    end else if (ver == gre_pkg::VER_PPTP) begin
                        if ((pk_flags_hi & 8'hCF) != 8'h00 || (pk_flags_lo & 8'h78) != 8'h00
                                || pk_proto != gre_pkg::PPP_PROTOCOL || !pk_flags_hi[5]) begin
                            pk_error = gre_pkg::ST_BAD_V1;
                        end else begin
                            hlen += 4;
                            if (pk_flags_hi[4]) hlen += 4;
                            if (pk_flags_lo[7]) hlen += 4;
                            pk_hdr_end = hlen;
                        end
                    end else begin
                        pk_error = gre_pkg::ST_BAD_VER;
                    end
                end
                default: ;
            endcase
        end else if (pos < LEN_LIMIT && pk_phase == PH_WALK) begin
            // pk_hdr_end points just past the header of the route entry being read.
            base = pk_hdr_end - 4;
            if (pos == base) begin
                pk_route_fam = {it.data_byte, 8'h00};
            end else if (pos == base + 1) begin
                pk_route_fam = pk_route_fam | {8'h00, it.data_byte};
            end else if (pos == base + 3) begin
                pk_route_len = it.data_byte;
                if (pk_route_fam == 16'h0000 && pk_route_len == 8'h00) begin
                    pk_phase = PH_PAYLOAD;
                end else if (pk_hdr_end + pk_route_len + 4 > LEN_LIMIT) begin
                    pk_hdr_end = LEN_LIMIT;
                    pk_error = gre_pkg::ST_TRUNC;
                    pk_phase = PH_PAYLOAD;
                end else begin
                    pk_hdr_end = pk_hdr_end + pk_route_len + 4;
                end
            end
        end

        if (!it.last_byte) return 1'b0;

        if (pk_count < 4) st = gre_pkg::ST_TRUNC;
        else if (pk_nested) st = gre_pkg::ST_NESTED;
        else if (pk_error != gre_pkg::ST_OK) st = pk_error;
        else if (pk_phase == PH_WALK || pk_hdr_end > pk_count) st = gre_pkg::ST_TRUNC;
        else st = gre_pkg::ST_OK;

        res.status = st;
        if (st == gre_pkg::ST_OK) begin
            res.header_length = pk_hdr_end[15:0];
            res.next_protocol = pk_proto;
        end
        pk_phase = PH_IDLE;
        return 1'b1;
    endfunction

    function automatic void append_byte(input logic [7:0] value);
        pkt_bytes.insert(pkt_bytes.size(), value);
    endfunction

    function automatic void add_random(input int n);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
    endfunction

    // Builds a valid GRE header with random options and option contents.
    function automatic void make_wellformed(input bit pptp);
        logic [7:0] hi;
        logic [7:0] lo;
        int         len;
        pkt_bytes.delete();
        if (pptp) begin
            hi = {3'b001, 1'($urandom_range(0, 1)), 4'b0000};
            lo = {1'($urandom_range(0, 1)), 4'b0000, gre_pkg::VER_PPTP};
            pkt_bytes = '{hi, lo, gre_pkg::PPP_PROTOCOL[15:8], gre_pkg::PPP_PROTOCOL[7:0]};
            add_random(4 + (hi[4] ? 4 : 0) + (lo[7] ? 4 : 0));
        end else begin
            hi = {4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 3'b000};
            lo = {5'b00000, gre_pkg::VER_RFC1701};
            pkt_bytes = '{hi, lo, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
            add_random(((hi[7] || hi[6]) ? 4 : 0) + (hi[5] ? 4 : 0) + (hi[4] ? 4 : 0));
            if (hi[6]) begin
                repeat ($urandom_range(0, 3)) begin
                    add_random(3);
                    len = $urandom_range(0, 12);
                    append_byte(8'(len));
                    add_random(len);
                end
                // Null entry; its offset byte carries no meaning.
                append_byte(8'h00);
                append_byte(8'h00);
                add_random(1);
                append_byte(8'h00);
            end
        end
    endfunction

    task automatic put_byte(input gre_pkg::t_in_item it, input bit typed = 1'b0,
                            input gre_pkg::t_out_item typed_res = '0);
        gre_pkg::t_out_item predicted;
        i_in_item <= it;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (gre_predict(it, predicted))
            gre_results.insert(gre_results.size(), typed ? typed_res : predicted);
        bytes_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 20);
        end
    endtask

    task automatic send_packet(input bit encaps, input bit open_end);
        gre_pkg::t_in_item it;
        foreach (pkt_bytes[i]) begin
            it.data_byte = pkt_bytes[i];
            it.first_byte = (i == 0);
            it.last_byte = !open_end && (i == pkt_bytes.size() - 1);
            it.already_encapsulated = (i == 0) ? encaps : 1'($urandom_range(0, 1));
            put_byte(it);
        end
        packets_sent++;
    endtask

    // Result side: checks every popped item and stalls on a rotating pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            rx_tick <= '0;
        end else begin
            if (pop && !empty) begin
                if (gre_results.size() == 0) begin
                    $error("result with nothing expected: status %0d", o_out_item.status);
                    fail_count++;
                end else begin
                    want_item = gre_results.pop_front();
                    results_checked++;
                    if (o_out_item.status != want_item.status) begin
                        $error("status: expected %0d, got %0d",
                               want_item.status, o_out_item.status);
                        fail_count++;
                    end
                    if (o_out_item.header_length != want_item.header_length) begin
                        $error("header_length: expected %0d, got %0d",
                               want_item.header_length, o_out_item.header_length);
                        fail_count++;
                    end
                    if (o_out_item.next_protocol != want_item.next_protocol) begin
                        $error("next_protocol: expected 0x%04h, got 0x%04h",
                               want_item.next_protocol, o_out_item.next_protocol);
                        fail_count++;
                    end
                end
            end
            rx_tick <= rx_tick + 1'b1;
            case (rx_tick[8:7])
                2'd0: pop <= 1'b1;
                2'd1: pop <= (rx_tick[1:0] != 2'b00);
                2'd2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (rx_tick[2:0] == 3'b000);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $error("no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int                sel;
        int                cut;
        int                random_bytes;
        int                long_len;
        gre_pkg::t_in_item stray;
        random_bytes = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(0, 20);

        foreach (directed_rows[i])
            put_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // One long packet with a maximum-length route entry: the packet ends while
        // the route walk is still open.
        pkt_bytes.delete();
        pkt_bytes = '{8'h40, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        add_random(4);
        while (pkt_bytes.size() < 260) begin
            append_byte(8'($urandom_range(1, 255)));
            add_random(2);
            append_byte(8'hFF);
            add_random(255);
        end
        long_len = pkt_bytes.size();
        send_packet(1'b0, 1'b0);

        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    stray.data_byte = 8'($urandom_range(0, 255));
                    stray.first_byte = 1'b0;
                    stray.last_byte = 1'($urandom_range(0, 1));
                    stray.already_encapsulated = 1'($urandom_range(0, 1));
                    put_byte(stray);
                end
            end
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                make_wellformed(sel >= 50);
                add_random($urandom_range(0, 16));
                if (sel % 5 == 0) begin
                    cut = $urandom_range(0, 3);
                    pkt_bytes[cut] = pkt_bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
                end else if (sel % 5 == 1) begin
                    cut = $urandom_range(1, pkt_bytes.size() - 1);
                    while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
                end
            end else begin
                pkt_bytes.delete();
                add_random($urandom_range(1, 12));
            end
            random_bytes += pkt_bytes.size();
            send_packet($urandom_range(0, 12) == 0, $urandom_range(0, 24) == 0);
        end
        push <= 1'b0;

        while (gre_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Pushed %0d bytes in %0d packets, one of them %0d bytes long;",
                 bytes_accepted, packets_sent, long_len);
        $display("%0d parser results compared field by field.", results_checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
